>>> hdl/bqf_pkg.sv
// Shared types, constants and saturation helpers for the biquad filter.
// Used by bqf_regs, bqf_mac and biquad_tdf2_filter; depends on nothing else.
package bqf_pkg;

  localparam int SAMPLE_W = 24;   // Q1.23 audio word
  localparam int COEF_W   = 32;   // Q4.28 coefficient
  localparam int STATE_W  = 48;   // Q8.40 delay register
  localparam int FB_W     = 32;   // Q8.24 feedback operand
  localparam int PROD_W   = 64;   // full multiplier product
  localparam int ACC_W    = 56;   // accumulator, wide enough for any partial sum
  localparam int ADDR_W   = 5;    // byte address of five 32-bit registers
  localparam int DATA_W   = 32;   // configuration bus data

  // Register indexes on the configuration port (byte address / 4)
  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  // Coefficient set handed from the register file to the datapath
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  // Control of the shared multiply-round-accumulate unit
  typedef struct packed {
    logic fb_term;   // feedback product: round by 12 instead of 11
    logic negate;    // subtract the rounded term from the addend
  } mac_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_FIN
  } seq_state_t;

  // Clamp an accumulator value into the 48-bit state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] res;
    if (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}}) begin
      res = v[STATE_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Round Q8.40 down to Q8.24 (ties upward) and clamp to 32 bits
  function automatic logic signed [FB_W-1:0] y_to_fb(input logic signed [STATE_W-1:0] y);
    logic signed [STATE_W:0]    biased;
    logic signed [STATE_W-16:0] shifted;
    logic signed [FB_W-1:0]     res;
    biased  = {y[STATE_W-1], y} + (STATE_W+1)'(1 << 15);
    shifted = biased[STATE_W:16];
    if (shifted[STATE_W-16:FB_W-1] == {(STATE_W-16-FB_W+2){shifted[STATE_W-16]}}) begin
      res = shifted[FB_W-1:0];
    end else if (shifted[STATE_W-16]) begin
      res = {1'b1, {(FB_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(FB_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Round Q8.40 down to Q1.23 (ties upward) and clamp to 24 bits
  function automatic logic signed [SAMPLE_W-1:0] y_to_out(input logic signed [STATE_W-1:0] y);
    logic signed [STATE_W:0]    biased;
    logic signed [STATE_W-17:0] shifted;
    logic signed [SAMPLE_W-1:0] res;
    biased  = {y[STATE_W-1], y} + (STATE_W+1)'(1 << 16);
    shifted = biased[STATE_W:17];
    if (shifted[STATE_W-17:SAMPLE_W-1] ==
        {(STATE_W-17-SAMPLE_W+2){shifted[STATE_W-17]}}) begin
      res = shifted[SAMPLE_W-1:0];
    end else if (shifted[STATE_W-17]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> hdl/bqf_regs.sv
// Coefficient register file behind the configuration port.
// Depends on bqf_pkg for the register indexes and the coefficient set type.
module bqf_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [bqf_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [bqf_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bqf_pkg::DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output bqf_pkg::coef_set_t        coefs
);
  import bqf_pkg::*;

  coef_set_t coefs_r;
  logic      wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[4:2];
  assign coefs      = coefs_r;

  // Write one coefficient per access phase; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.b0 <= COEF_W'(32'sh1000_0000);
      coefs_r.b1 <= '0;
      coefs_r.b2 <= '0;
      coefs_r.a1 <= '0;
      coefs_r.a2 <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_B0:  coefs_r.b0 <= cfg_pwdata;
        REG_B1:  coefs_r.b1 <= cfg_pwdata;
        REG_B2:  coefs_r.b2 <= cfg_pwdata;
        REG_A1:  coefs_r.a1 <= cfg_pwdata;
        REG_A2:  coefs_r.a2 <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed coefficient
  always_comb begin
    unique case (idx)
      REG_B0:  cfg_prdata = coefs_r.b0;
      REG_B1:  cfg_prdata = coefs_r.b1;
      REG_B2:  cfg_prdata = coefs_r.b2;
      REG_A1:  cfg_prdata = coefs_r.a1;
      REG_A2:  cfg_prdata = coefs_r.a2;
      default: cfg_prdata = '0;
    endcase
  end

endmodule

>>> hdl/bqf_mac.sv
// Shared multiply, round and accumulate unit of the biquad datapath.
// Depends on bqf_pkg for widths and the unit's control struct.
module bqf_mac (
  input  logic                              clk,
  input  logic signed [bqf_pkg::COEF_W-1:0] op_a,
  input  logic signed [bqf_pkg::COEF_W-1:0] op_b,
  input  bqf_pkg::mac_ctrl_t                ctrl,
  input  logic signed [bqf_pkg::ACC_W-1:0]  addend,
  output logic signed [bqf_pkg::ACC_W-1:0]  sum
);
  import bqf_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W:0]   biased;
  logic signed [PROD_W:0]   shifted;
  logic signed [ACC_W-1:0]  term;

  // Register the product before rounding
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Round to Q8.40, ties upward: feedforward drops 11 bits, feedback 12
  always_comb begin
    if (ctrl.fb_term) begin
      biased  = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(1 << 11);
      shifted = biased >>> 12;
    end else begin
      biased  = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(1 << 10);
      shifted = biased >>> 11;
    end
    term = shifted[ACC_W-1:0];
  end

  // Accumulate or subtract the rounded term
  assign sum = ctrl.negate ? (addend - term) : (addend + term);

endmodule

>>> hdl/biquad_tdf2_filter.sv
// Second-order IIR filter, transposed direct form II, with one shared multiplier.
// Depends on bqf_pkg, bqf_regs and bqf_mac.
//
// Each sample occupies the block for the idle state in which the word is taken,
// six steps P0 to P5 through the single 32x32 multiplier and its rounding
// accumulator (b0*x, b1*x, b2*x, a1*y, a2*y, with the last product summed one
// step after it is formed), and the state FIN that writes back the two 48-bit
// delay registers and loads the output register. The result word is offered
// from that register after write-back. in_tready is high only while the
// sequencer idles, so a new sample enters only after the previous one has left
// write-back; a result left waiting holds the write-back until out_tready rises.
// Coefficients are Q4.28 at byte addresses 0x00 (b0), 0x04 (b1), 0x08 (b2),
// 0x0C (a1) and 0x10 (a2), with b0 = 1.0 and the rest zero after reset; write
// them only between samples. Delay state and output saturate rather than wrap.
module biquad_tdf2_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  // slave stream: [23:0] sample_in
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,
  // master stream: [23:0] sample_out
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bqf_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [bqf_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [bqf_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import bqf_pkg::*;

  coef_set_t  coefs;
  seq_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [STATE_W-1:0]  d1_r, d2_r;
  logic signed [STATE_W-1:0]  y_wide_r;
  logic signed [FB_W-1:0]     y_fb_r;
  logic signed [ACC_W-1:0]    acc1_r, acc2_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;

  logic signed [COEF_W-1:0]   mac_a, mac_b;
  logic signed [ACC_W-1:0]    mac_addend, mac_sum;
  mac_ctrl_t                  mac_ctrl;
  logic                       in_take, fin_go;

  bqf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .coefs       (coefs)
  );

  bqf_mac u_mac (
    .clk    (clk),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .ctrl   (mac_ctrl),
    .addend (mac_addend),
    .sum    (mac_sum)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_take    = in_tvalid & in_tready;
  assign fin_go     = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_P0;
      ST_P0:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_P4;
      ST_P4:   state_nxt = ST_P5;
      ST_P5:   state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operands, addend and rounding mode for each step
  always_comb begin
    mac_a      = '0;
    mac_b      = '0;
    mac_addend = '0;
    mac_ctrl   = '0;
    unique case (state_r)
      ST_P0: begin
        mac_a = coefs.b0;
        mac_b = COEF_W'(x_r);
      end
      ST_P1: begin
        mac_a      = coefs.b1;
        mac_b      = COEF_W'(x_r);
        mac_addend = ACC_W'(d1_r);
      end
      ST_P2: begin
        mac_a      = coefs.b2;
        mac_b      = COEF_W'(x_r);
        mac_addend = ACC_W'(d2_r);
      end
      ST_P3: begin
        mac_a = coefs.a1;
        mac_b = y_fb_r;
      end
      ST_P4: begin
        mac_a      = coefs.a2;
        mac_b      = y_fb_r;
        mac_addend = acc1_r;
        mac_ctrl   = '{fb_term: 1'b1, negate: 1'b1};
      end
      ST_P5: begin
        mac_addend = acc2_r;
        mac_ctrl   = '{fb_term: 1'b1, negate: 1'b1};
      end
      default: ;
    endcase
  end

  // Sequencer and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Delay registers: update only at write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (fin_go) begin
      d1_r <= sat_state(acc1_r);
      d2_r <= sat_state(acc2_r);
    end
  end

  // Datapath capture for each step
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r <= in_tdata;
    end
    unique case (state_r)
      ST_P1:   y_wide_r <= sat_state(mac_sum);
      ST_P2: begin
        acc1_r <= mac_sum;
        y_fb_r <= y_to_fb(y_wide_r);
      end
      ST_P3:   acc2_r <= mac_sum;
      ST_P4:   acc1_r <= mac_sum;
      ST_P5:   acc2_r <= mac_sum;
      default: ;
    endcase
    if (fin_go) begin
      out_data_r <= y_to_out(y_wide_r);
    end
  end

  // Delay state moves only at write-back
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FIN) |=> ($stable(d1_r) && $stable(d2_r)))
    else $error("delay state changed outside write-back");

  // A new result appears only out of write-back
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FIN))
    else $error("result raised without write-back");

  // An accepted word starts the multiply sequence and closes the input
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_P0 && !in_tready))
    else $error("accepted word did not start the sequence");

  // Write-back never overruns a result still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_tready) |=> (state_r == ST_FIN))
    else $error("write-back overran a waiting result");

endmodule
